### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/gspa_pkg.sv
// Package for the greedy streaming partition assigner.
// Types, constants and the sequencer state enum; no dependencies.
package gspa_pkg;
    localparam int MAX_PARTS_DEF    = 16;
    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int MAX_NODES_DEF    = 65536;
    localparam int PART_SLOTS       = 16;
    localparam int TALLY_W          = 17;
    localparam int WIDE_W           = 32;
    localparam logic [4:0] PARTS_RESET = 5'd2;
    localparam logic [0:0] REG_PARTS   = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOKUP, ST_TALLY, ST_DIVIDE, ST_SCORE, ST_UPDATE, ST_CLEAR, ST_OUT
    } state_t;
endpackage

### rtl/greedy_streaming_partition_assign_top.sv
// Greedy streaming partition assigner, top level.
// A neighbor word passes through accept, node memory read and tally. A last word
// then goes on to a bit-serial divide of both totals, scoring, an update,
// clearing of the tallies and an output state, which waits while the previous
// result word is still held. After aresetn the node memory and the cluster member
// memory are swept with s_tready low; tallies zero, parts_in_use is 2.
module greedy_streaming_partition_assign_top #(
    parameter int MAX_PARTS    = gspa_pkg::MAX_PARTS_DEF,
    parameter int MAX_CLUSTERS = gspa_pkg::MAX_CLUSTERS_DEF,
    parameter int MAX_NODES    = gspa_pkg::MAX_NODES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] node_index, [19:16] cluster_index, [35:20] neighbor_index,
    // [36] neighbor_present, [39:37] zero
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,   // last_neighbor
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] placed_node, [19:16] chosen_part, [23:20] zero
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(MAX_NODES);
    localparam int TW = gspa_pkg::TALLY_W;
    localparam int WW = gspa_pkg::WIDE_W;
    localparam int SL = gspa_pkg::PART_SLOTS;
    localparam int LIM = (MAX_PARTS < SL) ? MAX_PARTS : SL;
    localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CM = SL * MAX_CLUSTERS;
    localparam int CAW = $clog2(CM);
    localparam int CCW = $clog2(CM + 1);
    localparam logic [TW-1:0] TMAX = '1;
    localparam logic [WW-1:0] WMAX = '1;

    gspa_pkg::state_t st_reg, st_next;
    logic [4:0] parts_reg;
    logic [15:0] node_reg;
    logic [3:0] clus_reg;
    logic [15:0] nb_reg;
    logic nbok_reg, last_reg;
    logic [TW-1:0] nt_reg [SL];
    logic [TW-1:0] visit_reg;
    logic [WW-1:0] inner_reg [SL];
    logic [WW-1:0] cut_reg [SL];
    logic [WW-1:0] tin_reg, tcut_reg;
    logic [WW-1:0] elim_reg, clim_reg;
    logic [TW-1:0] cm_mem [CM];
    logic [TW-1:0] cm_rd_reg;
    logic [4:0] i_reg;
    logic [3:0] best_reg;
    logic [TW+1:0] bscore_reg;
    logic div_phase_reg;
    logic [15:0] onode_reg;
    logic [3:0] opart_reg;
    logic ovalid_reg;
    logic div_start, div_busy;
    logic [WW-1:0] quo;
    logic [4:0] p_eff;
    logic rd_placed, clearing, cm_clearing;
    logic [3:0] rd_part;
    logic [CW-1:0] clus_m;
    logic [CW-1:0] clus_tab [16];
    logic [3:0] pi;
    logic [3:0] sp;
    logic [TW+1:0] score_d;
    logic take;
    logic [3:0] best_now;
    logic [TW-1:0] in_sh, out_sh;

    assign p_eff = (parts_reg == 5'd0) ? 5'd1 :
                   (parts_reg > 5'(LIM)) ? 5'(LIM) : parts_reg;

    // Cluster label folded into the configured cluster range
    for (genvar k = 0; k < 16; k++) begin : g_clus
        assign clus_tab[k] = CW'(k % MAX_CLUSTERS);
    end
    assign clus_m = clus_tab[clus_reg];

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == gspa_pkg::REG_PARTS) ? {27'd0, parts_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) parts_reg <= gspa_pkg::PARTS_RESET;
        else if (psel && penable && pwrite && paddr[2] == gspa_pkg::REG_PARTS)
            parts_reg <= pwdata[4:0];
    end

    gspa_node_mem #(.MAX_NODES(MAX_NODES)) u_mem (
        .aclk(aclk), .aresetn(aresetn),
        .rd_addr(AW'(nb_reg)), .rd_placed(rd_placed), .rd_part(rd_part),
        .wr_en(st_reg == gspa_pkg::ST_UPDATE && ({16'd0, node_reg} < 32'(MAX_NODES))),
        .wr_addr(AW'(node_reg)), .wr_part(best_reg), .clearing(clearing)
    );

    // Inner total divided first (started from TALLY), cut total second
    gspa_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend((st_reg == gspa_pkg::ST_DIVIDE) ? tcut_reg : tin_reg),
        .divisor(p_eff), .busy(div_busy), .quotient(quo)
    );

    // Cluster table read address for part i_reg
    assign pi = i_reg[3:0];

    // Sequencer
    always_comb begin
        st_next = st_reg;
        div_start = 1'b0;
        case (st_reg)
            gspa_pkg::ST_IDLE:   if (s_tvalid && s_tready) st_next = gspa_pkg::ST_LOOKUP;
            gspa_pkg::ST_LOOKUP: st_next = gspa_pkg::ST_TALLY;
            gspa_pkg::ST_TALLY: begin
                if (last_reg) begin
                    st_next = gspa_pkg::ST_DIVIDE;
                    div_start = 1'b1;
                end else st_next = gspa_pkg::ST_IDLE;
            end
            gspa_pkg::ST_DIVIDE: begin
                if (!div_busy) begin
                    if (!div_phase_reg) div_start = 1'b1;
                    else st_next = gspa_pkg::ST_SCORE;
                end
            end
            gspa_pkg::ST_SCORE:  if (i_reg == p_eff) st_next = gspa_pkg::ST_UPDATE;
            gspa_pkg::ST_UPDATE: st_next = gspa_pkg::ST_CLEAR;
            gspa_pkg::ST_CLEAR:  if (i_reg == 5'(SL - 1)) st_next = gspa_pkg::ST_OUT;
            gspa_pkg::ST_OUT:    if (!ovalid_reg || m_tready) st_next = gspa_pkg::ST_IDLE;
            default:             st_next = gspa_pkg::ST_IDLE;
        endcase
    end

    assign s_tready = (st_reg == gspa_pkg::ST_IDLE) && !clearing && !cm_clearing;

    assign in_sh = nt_reg[best_reg];
    assign out_sh = (visit_reg >= in_sh) ? visit_reg - in_sh : '0;

    // Compare pipeline: score of part i_reg-1 uses cm_rd_reg read last cycle
    assign sp = 4'(i_reg - 5'd1);
    always_comb begin
        score_d = {2'b0, cm_rd_reg} + (TW+2)'(1);
        if (visit_reg != '0 && nt_reg[sp] == '0) score_d = score_d + (TW+2)'(1);
        if (inner_reg[sp] > elim_reg && nt_reg[sp] != '0) score_d = score_d + (TW+2)'(1);
        if (tcut_reg != '0 && cut_reg[sp] > clim_reg &&
            ((visit_reg >= nt_reg[sp]) ? visit_reg - nt_reg[sp] : '0) != '0)
            score_d = score_d + (TW+2)'(1);
    end
    assign take = (st_reg == gspa_pkg::ST_SCORE) && (i_reg != 5'd0) && (score_d < bscore_reg);
    assign best_now = take ? sp : best_reg;

    function automatic logic [WW-1:0] wsat(input logic [WW-1:0] a, input logic [TW-1:0] b);
        logic [WW:0] s;
        s = {1'b0, a} + (WW+1)'(b);
        return s[WW] ? WMAX : s[WW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= gspa_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
            visit_reg <= '0;
            tin_reg <= '0;
            tcut_reg <= '0;
            div_phase_reg <= 1'b0;
            i_reg <= '0;
            for (int k = 0; k < SL; k++) begin
                nt_reg[k] <= '0;
                inner_reg[k] <= '0;
                cut_reg[k] <= '0;
            end
        end else begin
            st_reg <= st_next;
            case (st_reg)
                gspa_pkg::ST_TALLY: begin
                    if (nbok_reg && rd_placed) begin
                        if (nt_reg[rd_part] != TMAX)
                            nt_reg[rd_part] <= nt_reg[rd_part] + TW'(1);
                        if (visit_reg != TMAX) visit_reg <= visit_reg + TW'(1);
                    end
                    div_phase_reg <= 1'b0;
                end
                gspa_pkg::ST_DIVIDE: begin
                    if (!div_busy) begin
                        if (!div_phase_reg) begin
                            elim_reg <= quo;
                            div_phase_reg <= 1'b1;
                        end else begin
                            clim_reg <= quo;
                            i_reg <= '0;
                            bscore_reg <= '1;
                            best_reg <= '0;
                        end
                    end
                end
                gspa_pkg::ST_SCORE: begin
                    // i_reg is one ahead of cm_rd_reg; first cycle only primes the read
                    i_reg <= i_reg + 5'd1;
                    if (take) begin
                        bscore_reg <= score_d;
                        best_reg <= sp;
                    end
                end
                gspa_pkg::ST_UPDATE: begin
                    inner_reg[best_reg] <= wsat(inner_reg[best_reg], in_sh);
                    cut_reg[best_reg] <= wsat(cut_reg[best_reg], out_sh);
                    tin_reg <= wsat(tin_reg, in_sh);
                    tcut_reg <= wsat(tcut_reg, out_sh);
                    i_reg <= '0;
                end
                gspa_pkg::ST_CLEAR: begin
                    if (i_reg < p_eff && i_reg[3:0] != best_reg)
                        cut_reg[i_reg[3:0]] <= wsat(cut_reg[i_reg[3:0]], nt_reg[i_reg[3:0]]);
                    nt_reg[i_reg[3:0]] <= '0;
                    visit_reg <= '0;
                    i_reg <= i_reg + 5'd1;
                end
                gspa_pkg::ST_OUT: begin
                    if (!ovalid_reg || m_tready) begin
                        onode_reg <= node_reg;
                        opart_reg <= best_reg;
                    end
                end
                default: ;
            endcase
            // result word register
            if (st_reg == gspa_pkg::ST_OUT && (!ovalid_reg || m_tready)) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
        end
        // input capture
        if (s_tvalid && s_tready) begin
            node_reg <= s_tdata[15:0];
            clus_reg <= s_tdata[19:16];
            nb_reg <= s_tdata[35:20];
            nbok_reg <= s_tdata[36] && ({16'd0, s_tdata[35:20]} < 32'(MAX_NODES));
            last_reg <= s_tlast;
        end
    end

    // Cluster member memory, cleared by sweep alongside node memory
    logic [CAW-1:0] cm_addr;
    logic [CAW-1:0] cm_faddr;
    logic [CAW-1:0] cm_waddr;
    logic [CCW-1:0] cm_clr_reg;
    assign cm_addr = CAW'(pi * MAX_CLUSTERS + clus_m);
    assign cm_faddr = CAW'(best_now * MAX_CLUSTERS + clus_m);
    assign cm_waddr = CAW'(best_reg * MAX_CLUSTERS + clus_m);
    assign cm_clearing = (cm_clr_reg != CCW'(CM));
    always_ff @(posedge aclk) begin
        if (!aresetn) cm_clr_reg <= '0;
        else if (cm_clearing) cm_clr_reg <= cm_clr_reg + CCW'(1);
    end
    // last scoring cycle reads the entry of the final winner for the update
    always_ff @(posedge aclk) begin
        if (cm_clearing)
            cm_mem[cm_clr_reg[CAW-1:0]] <= '0;
        else if (st_reg == gspa_pkg::ST_UPDATE && cm_rd_reg != TMAX)
            cm_mem[cm_waddr] <= cm_rd_reg + TW'(1);
        cm_rd_reg <= cm_mem[(st_reg == gspa_pkg::ST_SCORE && i_reg == p_eff) ?
                            cm_faddr : cm_addr];
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata = {4'd0, opart_reg, onode_reg};
endmodule

### rtl/gspa_div.sv
// Bit-serial unsigned divider, 32 bits by 5 bits, one quotient bit a cycle.
// Uses gspa_pkg.
module gspa_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [gspa_pkg::WIDE_W-1:0] dividend,
    input  logic [4:0]                  divisor,
    output logic                        busy,
    output logic [gspa_pkg::WIDE_W-1:0] quotient
);
    localparam int W = gspa_pkg::WIDE_W;
    logic [W-1:0] q_reg, q_next;
    logic [5:0]   r_reg, r_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic [5:0]   trial;

    // Restoring division step
    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg[4:0], q_reg[W-1]};
        if (start) begin
            q_next = dividend;
            r_next = '0;
            cnt_next = 6'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                r_next = trial - {1'b0, divisor};
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy = busy_reg;
    assign quotient = q_reg;
endmodule

### rtl/gspa_node_mem.sv
// Node memory: placed flag and part per node, one read and one write port.
// Cleared by a sweep after reset. Uses gspa_pkg.
module gspa_node_mem #(
    parameter int MAX_NODES = gspa_pkg::MAX_NODES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
    output logic                         rd_placed,
    output logic [3:0]                   rd_part,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
    input  logic [3:0]                   wr_part,
    output logic                         clearing
);
    localparam int AW = $clog2(MAX_NODES);
    logic [4:0] mem [MAX_NODES];
    logic [AW:0] clr_reg;
    logic [4:0] rd_reg;

    // Clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) clr_reg <= '0;
        else if (!clr_reg[AW]) clr_reg <= clr_reg + (AW+1)'(1);
    end
    assign clearing = !clr_reg[AW];

    always_ff @(posedge aclk) begin
        if (clearing) mem[clr_reg[AW-1:0]] <= '0;
        else if (wr_en) mem[wr_addr] <= {1'b1, wr_part};
        rd_reg <= mem[rd_addr];
    end
    assign rd_placed = rd_reg[4];
    assign rd_part = rd_reg[3:0];
endmodule

### rtl/gspa_checker.sv
// Port checker for the partition assigner, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"
module gspa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    // A pending result stays until taken
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    // The block takes no word in the cycle after accepting one
    `ASSERT_NEXT(a_seq, aclk, aresetn, s_tvalid && s_tready, !s_tready, "back-to-back accept")
    // Padding bits are zero
    `ASSERT_IMPL(a_pad, aclk, aresetn, m_tvalid, m_tdata[23:20] == 4'd0, "padding set")
endmodule

bind greedy_streaming_partition_assign_top gspa_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### verif/greedy_streaming_partition_assign_top_tb.sv
// Self-checking testbench for the greedy streaming partition assigner.
// Depends on gspa_pkg and greedy_streaming_partition_assign_top; drives node runs,
// predicts each placement and checks every result word in order.
`timescale 1ns / 1ps

module greedy_streaming_partition_assign_top_tb;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  DRAIN_WAIT  = 200;
    localparam int  PHASES      = 8;
    localparam int  PHASE_WORDS = 150;
    localparam int  HOLD_LEN    = 3000;

    typedef struct {
        logic [15:0] node;
        logic [3:0]  cluster;
        logic [15:0] neighbor;
        logic        present;
        logic        last;
    } nb_word_t;

    typedef struct {
        logic [15:0] node;
        logic [3:0]  part;
    } placement_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    greedy_streaming_partition_assign_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock, 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state
    bit                placed [65536];
    logic [3:0]        home_part [65536];
    logic [16:0]       nb_in_part [gspa_pkg::PART_SLOTS];
    logic [16:0]       nb_placed;
    logic [31:0]       inner_edges [gspa_pkg::PART_SLOTS];
    logic [31:0]       cut_edges [gspa_pkg::PART_SLOTS];
    logic [16:0]       cluster_members [gspa_pkg::PART_SLOTS][16];
    logic [31:0]       inner_total;
    logic [31:0]       cut_total;
    logic [4:0]        parts_cfg = gspa_pkg::PARTS_RESET;

    nb_word_t          pending_words [$];
    placement_t        expected_placements [$];
    nb_word_t          cur_word;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    bit                hold_on = 1'b0;
    bit                hold_done = 1'b0;
    int                fail_count = 0;
    int                placements_seen = 0;
    int                words_sent = 0;
    int                cycle_count = 0;

    function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [16:0] inc17(input logic [16:0] a);
        return (a == 17'h1FFFF) ? a : a + 17'd1;
    endfunction

    // Work out the placement caused by one accepted word
    task automatic place_word(input nb_word_t w);
        int          p;
        logic [31:0] score, best_score, edge_lim, cut_lim;
        logic [16:0] nei, outside, in_share, out_share;
        logic [3:0]  best;
        if (w.present && placed[w.neighbor]) begin
            nb_in_part[home_part[w.neighbor]] = inc17(nb_in_part[home_part[w.neighbor]]);
            nb_placed = inc17(nb_placed);
        end
        if (!w.last) return;
        p = (parts_cfg == 0) ? 1 :
            (parts_cfg > gspa_pkg::PART_SLOTS) ? gspa_pkg::PART_SLOTS : int'(parts_cfg);
        edge_lim = inner_total / p;
        cut_lim = cut_total / p;
        best = '0;
        best_score = 32'hFFFF_FFFF;
        for (int i = 0; i < p; i++) begin
            nei = nb_in_part[i];
            outside = (nb_placed >= nei) ? nb_placed - nei : '0;
            score = 32'd1 + cluster_members[i][w.cluster];
            if (nb_placed != 0 && nei == 0) score++;
            if (inner_edges[i] > edge_lim && nei > 0) score++;
            if (cut_total != 0 && cut_edges[i] > cut_lim && outside > 0) score++;
            if (score < best_score) begin
                best_score = score;
                best = 4'(i);
            end
        end
        in_share = nb_in_part[best];
        out_share = (nb_placed >= in_share) ? nb_placed - in_share : '0;
        placed[w.node] = 1'b1;
        home_part[w.node] = best;
        inner_edges[best] = sat32(inner_edges[best], 32'(in_share));
        cut_edges[best] = sat32(cut_edges[best], 32'(out_share));
        cluster_members[best][w.cluster] = inc17(cluster_members[best][w.cluster]);
        inner_total = sat32(inner_total, 32'(in_share));
        cut_total = sat32(cut_total, 32'(out_share));
        for (int i = 0; i < p; i++)
            if (i != best) cut_edges[i] = sat32(cut_edges[i], 32'(nb_in_part[i]));
        for (int i = 0; i < gspa_pkg::PART_SLOTS; i++) nb_in_part[i] = '0;
        nb_placed = '0;
        expected_placements.insert(expected_placements.size(), '{node: w.node, part: best});
    endtask

    // Driver: predicts the word just taken, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                place_word(cur_word);
                words_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {3'b000, cur_word.present, cur_word.neighbor,
                                cur_word.cluster, cur_word.node};
                    s_tlast <= cur_word.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result word with the oldest expectation
    always @(posedge aclk) begin
        placement_t exp_p;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                placements_seen++;
                if (expected_placements.size() == 0) begin
                    $error("unexpected result word: placed_node %0d chosen_part %0d",
                           m_tdata[15:0], m_tdata[19:16]);
                    fail_count++;
                end else begin
                    exp_p = expected_placements.pop_front();
                    if (m_tdata[15:0] !== exp_p.node) begin
                        $error("placed_node: expected %0d, got %0d", exp_p.node, m_tdata[15:0]);
                        fail_count++;
                    end
                    if (m_tdata[19:16] !== exp_p.part) begin
                        $error("chosen_part: expected %0d, got %0d", exp_p.part,
                               m_tdata[19:16]);
                        fail_count++;
                    end
                end
            end
            if (hold_on) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("greedy_streaming_partition_assign_top_tb failed");
            $finish;
        end
    end

    task automatic push_word(input logic [15:0] node, input logic [3:0] cluster,
                             input logic [15:0] neighbor, input logic present,
                             input logic last);
        pending_words.insert(pending_words.size(),
                             '{node: node, cluster: cluster, neighbor: neighbor,
                               present: present, last: last});
    endtask

    function automatic logic [15:0] pick_node();
        return ($urandom_range(99) < 75) ? 16'($urandom_range(63)) : 16'($urandom);
    endfunction

    // One node run with random content; sometimes junk on the non-last words
    task automatic push_random_run();
        logic [15:0] node;
        logic [3:0]  cluster;
        int          len;
        node = pick_node();
        cluster = 4'($urandom);
        len = ($urandom_range(99) < 10) ? 1 : $urandom_range(2, 7);
        for (int k = 0; k < len; k++) begin
            if (k < len - 1 && $urandom_range(99) < 10)
                push_word(16'($urandom), 4'($urandom), pick_node(),
                          ($urandom_range(99) < 85), 1'b0);
            else
                push_word(node, cluster, pick_node(),
                          (len > 1) && ($urandom_range(99) < 90), k == len - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_tvalid || expected_placements.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_parts(input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(gspa_pkg::REG_PARTS) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        parts_cfg = value[4:0];
    endtask

    // Stimulus sequence
    initial begin
        int parts_seq [PHASES] = '{2, 16, 1, 0, 31, 5, 3, 16};
        int idle_modes [4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{15, 15}};
        int start_words;
        for (int i = 0; i < gspa_pkg::PART_SLOTS; i++) begin
            nb_in_part[i] = '0;
            inner_edges[i] = '0;
            cut_edges[i] = '0;
            for (int c = 0; c < 16; c++) cluster_members[i][c] = '0;
        end
        nb_placed = '0;
        inner_total = '0;
        cut_total = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty node, stray neighbor fields, extremes, repeat placement
        push_word(16'd0, 4'd0, 16'hFFFF, 1'b0, 1'b1);
        push_word(16'd1, 4'd15, 16'd0, 1'b1, 1'b1);
        push_word(16'hFFFF, 4'd15, 16'd0, 1'b1, 1'b0);
        push_word(16'hFFFF, 4'd15, 16'd1, 1'b1, 1'b0);
        push_word(16'hFFFF, 4'd15, 16'hFFFF, 1'b1, 1'b0);
        push_word(16'hFFFF, 4'd15, 16'hFFFF, 1'b0, 1'b1);
        push_word(16'd2, 4'd7, 16'hFFFF, 1'b1, 1'b1);
        push_word(16'd0, 4'd0, 16'd1, 1'b1, 1'b0);
        push_word(16'd0, 4'd0, 16'd2, 1'b1, 1'b1);
        push_word(16'hAAAA, 4'd5, 16'h5555, 1'b1, 1'b0);
        push_word(16'h5555, 4'd10, 16'hAAAA, 1'b1, 1'b1);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) write_parts({3'($urandom_range(0, 7)), 24'd0, 5'(parts_seq[ph])});
            send_idle_pct = idle_modes[ph % 4][0];
            recv_stall_pct = idle_modes[ph % 4][1];
            start_words = words_sent;
            while (words_sent - start_words < PHASE_WORDS) begin
                // long receiver hold-off while the sender keeps offering
                if (ph == 1 && words_sent - start_words >= 40 && !hold_done) begin
                    hold_done = 1'b1;
                    fork
                        begin
                            hold_on = 1'b1;
                            repeat (HOLD_LEN) @(posedge aclk);
                            hold_on = 1'b0;
                        end
                    join_none
                end
                if (pending_words.size() < 8) push_random_run();
                @(posedge aclk);
            end
            wait_drained();
        end

        $display("covered %0d neighbour words, %0d placements, %0d part settings",
                 words_sent, placements_seen, PHASES);
        if (fail_count == 0) begin
            $display("greedy_streaming_partition_assign_top_tb passed");
        end else begin
            $display("greedy_streaming_partition_assign_top_tb failed");
        end
        $finish;
    end
endmodule

### greedy_streaming_partition_assign_top.f
+incdir+rtl
rtl/gspa_pkg.sv
rtl/gspa_div.sv
rtl/gspa_node_mem.sv
rtl/greedy_streaming_partition_assign_top.sv
rtl/gspa_checker.sv
verif/greedy_streaming_partition_assign_top_tb.sv
